[design/plcm_pkg.sv]
package plcm_pkg;

  localparam int MAX_POINTS = 16;
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIV_CNT_W  = $clog2(FRAC_W + 1);
  localparam int PROD_W     = DATA_W + FRAC_W + 2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_EVAL  = 2'd2
  } op_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic             clear;
    logic             insert;
    logic [CNT_W-1:0] pos;
  } tbl_ctl_t;

endpackage

[design/plcm_if.sv]
interface plcm_in_if;
  import plcm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output op, output point_x, output point_y, output sample,
                  input ready);
  modport sink (input valid, input op, input point_x, input point_y, input sample,
                output ready);
endinterface

interface plcm_out_if;
  import plcm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] mapped_value;
  logic                     status;

  modport source (output valid, output mapped_value, output status, input ready);
  modport sink (input valid, input mapped_value, input status, output ready);
endinterface

[design/plcm_table.sv]
module plcm_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  plcm_pkg::tbl_ctl_t                 ctl,
  input  logic signed [plcm_pkg::DATA_W-1:0] ins_x,
  input  logic signed [plcm_pkg::DATA_W-1:0] ins_y,
  input  logic [plcm_pkg::IDX_W-1:0]         rd_idx,
  output logic signed [plcm_pkg::DATA_W-1:0] rd_x,
  output logic signed [plcm_pkg::DATA_W-1:0] rd_y,
  output logic [plcm_pkg::CNT_W-1:0]         count
);
  import plcm_pkg::*;

  logic signed [DATA_W-1:0] xs_r [MAX_POINTS];
  logic signed [DATA_W-1:0] ys_r [MAX_POINTS];
  logic [CNT_W-1:0]         count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clear) begin
      count_r <= '0;
    end else if (ctl.insert) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // An insert opens a gap at pos by moving every stored point at or above pos up one entry.
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (ctl.insert) begin
        if (CNT_W'(k) == ctl.pos) begin
          xs_r[k] <= ins_x;
          ys_r[k] <= ins_y;
        end else if (k > 0 && CNT_W'(k) > ctl.pos && CNT_W'(k) <= count_r) begin
          xs_r[k] <= xs_r[(k > 0) ? k - 1 : 0];
          ys_r[k] <= ys_r[(k > 0) ? k - 1 : 0];
        end
      end
    end
  end

  assign rd_x  = xs_r[rd_idx];
  assign rd_y  = ys_r[rd_idx];
  assign count = count_r;

endmodule

[design/plcm_div.sv]
module plcm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [plcm_pkg::DATA_W-1:0]  num,
  input  logic [plcm_pkg::DATA_W-1:0]  den,
  output logic                         done,
  output logic [plcm_pkg::FRAC_W-1:0]  quot
);
  import plcm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    rem_nxt;
  logic [DATA_W-1:0]    den_r;
  logic [FRAC_W-1:0]    quot_r;
  logic [FRAC_W-1:0]    quot_nxt;
  logic [DATA_W:0]      shifted;
  logic [DATA_W+1:0]    diff;
  logic                 fits;

  // Restoring division, one quotient bit a cycle; the remainder stays below den.
  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    fits     = !diff[DATA_W+1];
    rem_nxt  = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    quot_nxt = {quot_r[FRAC_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(FRAC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[design/piecewise_linear_curve_map_top.sv]
// Piecewise linear curve map over a sorted table of up to 16 control points.
// Input words arrive on in_chan (valid/ready): op selects clear, add point or
// evaluate sample. Every input word produces exactly one output word on
// out_chan (valid/ready) carrying mapped_value and status.
// in_chan.ready is high only while the sequencer is idle, so one word is in
// work at a time. Clear and unused codes go straight to the finish state. An
// add walks the table one entry per cycle to find its slot, then shifts and
// writes as the slot is found. An evaluate walks the table one entry per
// cycle, loads the lower neighbor, then runs a restoring divider that
// produces one bit of the 16-bit weight per cycle, followed by a multiply
// state and an add state.
// Evaluates at the table ends or with fewer than two points finish early.
// A finished word sits in the output register; the next input word is taken
// while it waits, and a later result holds until the receiver takes it.
// Reset empties the table; no clearing pass is needed.
module piecewise_linear_curve_map_top (
  input logic        clk,
  input logic        rst_n,
  plcm_in_if.sink    in_chan,
  plcm_out_if.source out_chan
);
  import plcm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SRCH,
    ST_EVAL_SRCH,
    ST_LOAD_LAST,
    ST_LOAD_LO,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_FINISH
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] px_r, px_nxt;
  logic signed [DATA_W-1:0] py_r, py_nxt;
  logic signed [DATA_W-1:0] smp_r, smp_nxt;
  logic signed [DATA_W-1:0] x_hi_r, x_hi_nxt;
  logic signed [DATA_W-1:0] y_hi_r, y_hi_nxt;
  logic signed [DATA_W-1:0] y_lo_r, y_lo_nxt;
  logic signed [DATA_W:0]   dy_r, dy_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DATA_W-1:0] res_value_r, res_value_nxt;
  logic                     res_status_r, res_status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_status_r, out_status_nxt;

  tbl_ctl_t                 tbl_ctl;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;
  logic [CNT_W-1:0]         count;
  logic                     div_start;
  logic [DATA_W-1:0]        div_num;
  logic [DATA_W-1:0]        div_den;
  logic                     div_done;
  logic [FRAC_W-1:0]        alpha;

  plcm_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (tbl_ctl),
    .ins_x  (px_r),
    .ins_y  (py_r),
    .rd_idx (idx_r[IDX_W-1:0]),
    .rd_x   (rd_x),
    .rd_y   (rd_y),
    .count  (count)
  );

  plcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (alpha)
  );

  // The lower neighbor is on the read port in ST_LOAD_LO; both differences are nonnegative.
  assign div_num = DATA_W'(smp_r - rd_x);
  assign div_den = DATA_W'(x_hi_r - rd_x);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    smp_nxt        = smp_r;
    x_hi_nxt       = x_hi_r;
    y_hi_nxt       = y_hi_r;
    y_lo_nxt       = y_lo_r;
    dy_nxt         = dy_r;
    prod_nxt       = prod_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    tbl_ctl        = '0;
    div_start      = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          px_nxt         = in_chan.point_x;
          py_nxt         = in_chan.point_y;
          smp_nxt        = in_chan.sample;
          idx_nxt        = '0;
          res_value_nxt  = '0;
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_FINISH;
          case (in_chan.op)
            OP_CLEAR: begin
              tbl_ctl.clear = 1'b1;
            end
            OP_ADD: begin
              if (count == CNT_W'(MAX_POINTS)) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                state_nxt = ST_ADD_SRCH;
              end
            end
            OP_EVAL: begin
              if (count < CNT_W'(2)) begin
                res_value_nxt = in_chan.sample;
              end else begin
                state_nxt = ST_EVAL_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_SRCH: begin
        // The new point goes after every stored point with equal or smaller x.
        if (idx_r == count || rd_x > px_r) begin
          tbl_ctl.insert = 1'b1;
          tbl_ctl.pos    = idx_r;
          state_nxt      = ST_FINISH;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_EVAL_SRCH: begin
        if (idx_r == count) begin
          idx_nxt   = idx_r - CNT_W'(1);
          state_nxt = ST_LOAD_LAST;
        end else if (smp_r < rd_x) begin
          if (idx_r == '0) begin
            res_value_nxt = rd_y;
            state_nxt     = ST_FINISH;
          end else begin
            x_hi_nxt  = rd_x;
            y_hi_nxt  = rd_y;
            idx_nxt   = idx_r - CNT_W'(1);
            state_nxt = ST_LOAD_LO;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_LOAD_LAST: begin
        res_value_nxt = rd_y;
        state_nxt     = ST_FINISH;
      end
      ST_LOAD_LO: begin
        y_lo_nxt  = rd_y;
        dy_nxt    = {y_hi_r[DATA_W-1], y_hi_r} - {rd_y[DATA_W-1], rd_y};
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = dy_r * $signed({1'b0, alpha});
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // Dropping the low fraction bits of a signed product rounds toward minus infinity.
        res_value_nxt = y_lo_r + prod_r[FRAC_W+DATA_W-1:FRAC_W];
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      px_r         <= px_nxt;
      py_r         <= py_nxt;
      smp_r        <= smp_nxt;
      x_hi_r       <= x_hi_nxt;
      y_hi_r       <= y_hi_nxt;
      y_lo_r       <= y_lo_nxt;
      dy_r         <= dy_nxt;
      prod_r       <= prod_nxt;
      res_value_r  <= res_value_nxt;
      res_status_r <= res_status_nxt;
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.mapped_value = out_value_r;
  assign out_chan.status       = out_status_r;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import plcm_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int WORDS_PER_PHASE = 470;
  localparam int NUM_DIR = 21;

  typedef struct packed {
    logic signed [DATA_W-1:0] mapped_value;
    logic                     status;
  } result_t;

  typedef struct {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] smp;
    int                       reps;
    bit                       typed;
    result_t                  want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  plcm_in_if  in_chan ();
  plcm_out_if out_chan ();

  piecewise_linear_curve_map_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted copy of the curve table.
  logic signed [DATA_W-1:0] curve_xs [MAX_POINTS];
  logic signed [DATA_W-1:0] curve_ys [MAX_POINTS];
  int curve_len = 0;

  result_t expected_results [$];
  dir_row_t dir_plan [NUM_DIR];

  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int n_words = 0;
  int n_clear = 0;
  int n_add = 0;
  int n_refused = 0;
  int n_eval = 0;
  int n_interp = 0;

  function automatic logic signed [DATA_W-1:0] map_sample(input logic signed [DATA_W-1:0] smp);
    int i;
    int lo;
    int hi;
    longint num;
    longint den;
    longint alpha;
    longint dy;
    if (curve_len < 2) return smp;
    i = 0;
    while (i < curve_len && smp >= curve_xs[i]) i++;
    lo = (i == 0) ? 0 : i - 1;
    hi = (i >= curve_len) ? curve_len - 1 : i;
    if (lo == hi) return curve_ys[hi];
    n_interp++;
    num = longint'(smp) - longint'(curve_xs[lo]);
    den = longint'(curve_xs[hi]) - longint'(curve_xs[lo]);
    alpha = (num <<< FRAC_W) / den;
    if (alpha > 65535) alpha = 65535;
    dy = longint'(curve_ys[hi]) - longint'(curve_ys[lo]);
    // An arithmetic shift of the signed product rounds toward minus infinity.
    return DATA_W'(longint'(curve_ys[lo]) + ((dy * alpha) >>> FRAC_W));
  endfunction

  function automatic result_t predict_word(input logic [1:0] op,
                                           input logic signed [DATA_W-1:0] px, py, smp);
    result_t r;
    int pos;
    r.mapped_value = '0;
    r.status = STATUS_OK;
    case (op)
      OP_CLEAR: begin
        curve_len = 0;
        n_clear++;
      end
      OP_ADD: begin
        n_add++;
        if (curve_len >= MAX_POINTS) begin
          r.status = STATUS_FULL;
          n_refused++;
        end else begin
          // Equal x values keep their order of arrival.
          pos = 0;
          while (pos < curve_len && curve_xs[pos] <= px) pos++;
          for (int k = curve_len; k > pos; k--) begin
            curve_xs[k] = curve_xs[k-1];
            curve_ys[k] = curve_ys[k-1];
          end
          curve_xs[pos] = px;
          curve_ys[pos] = py;
          curve_len++;
        end
      end
      OP_EVAL: begin
        n_eval++;
        r.mapped_value = map_sample(smp);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic signed [DATA_W-1:0] px, py, smp,
                           input bit typed = 1'b0, input result_t typed_res = '0);
    result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.op      <= op;
    in_chan.point_x <= px;
    in_chan.point_y <= py;
    in_chan.sample  <= smp;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    r = predict_word(op, px, py, smp);
    expected_results.push_back(typed ? typed_res : r);
    if (op != OP_SPARE) n_words++;
  endtask

  function automatic logic signed [DATA_W-1:0] random_coord(input int mode);
    logic signed [DATA_W-1:0] v;
    v = $urandom;
    if (mode == 1) begin
      v = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    end else if (mode == 2 && curve_len > 0 && $urandom_range(1) == 0) begin
      v = curve_xs[$urandom_range(0, curve_len - 1)];
    end
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_sample();
    longint span;
    longint off;
    int pick;
    pick = $urandom_range(9);
    if (curve_len == 0 || pick < 2) return $urandom;
    if (pick < 4) return curve_xs[$urandom_range(0, curve_len - 1)];
    span = longint'(curve_xs[curve_len-1]) - longint'(curve_xs[0]);
    off = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (span + 1);
    return DATA_W'(longint'(curve_xs[0]) + off);
  endfunction

  // One curve: an optional clear, a run of adds, a run of evaluates, then now and then a spare or random word.
  task automatic send_curve(input int base_idle, input int base_stall);
    int npts;
    int mode;
    if ($urandom_range(3) == 0) begin
      send_idle_pct = 0;
      stall_pct = 0;
    end else begin
      send_idle_pct = base_idle;
      stall_pct = base_stall;
    end
    if ($urandom_range(2) != 0) send_word(OP_CLEAR, $urandom, $urandom, $urandom);
    npts = ($urandom_range(9) < 6) ? $urandom_range(2, 6) : $urandom_range(0, 18);
    mode = $urandom_range(2);
    repeat (npts) send_word(OP_ADD, random_coord(mode), random_coord(mode), $urandom);
    repeat ($urandom_range(4, 12)) send_word(OP_EVAL, $urandom, $urandom, random_sample());
    if ($urandom_range(9) == 0) send_word(OP_SPARE, $urandom, $urandom, $urandom);
    if ($urandom_range(19) == 0) send_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: mapped_value %h status %b",
               out_chan.mapped_value, out_chan.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_chan.mapped_value !== want.mapped_value) begin
          $error("mapped_value: expected %h, got %h", want.mapped_value, out_chan.mapped_value);
          errors++;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_chan.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.op      <= OP_CLEAR;
    in_chan.point_x <= '0;
    in_chan.point_y <= '0;
    in_chan.sample  <= '0;

    dir_plan = '{
      // Empty table passes samples through, including both extremes.
      '{OP_EVAL, 32'h0, 32'h0, 32'h7FFF_FFFF, 1, 1'b1, '{32'h7FFF_FFFF, STATUS_OK}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h8000_0000, 1, 1'b1, '{32'h8000_0000, STATUS_OK}},
      '{OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, '{32'h0, STATUS_OK}},
      '{OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1, 1'b1, '{32'h0, STATUS_OK}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h1234_5678, 1, 1'b1, '{32'h1234_5678, STATUS_OK}},
      '{OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 1'b1, '{32'h0, STATUS_OK}},
      // Full-span segment with the steepest descent.
      '{OP_EVAL, 32'h0, 32'h0, 32'h8000_0000, 1, 1'b0, '{32'h0, STATUS_OK}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h7FFF_FFFF, 1, 1'b1, '{32'h8000_0000, STATUS_OK}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h0, 1, 1'b0, '{32'h0, STATUS_OK}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h7FFF_FFFE, 1, 1'b0, '{32'h0, STATUS_OK}},
      '{OP_CLEAR, 32'h0, 32'h0, 32'h0, 1, 1'b1, '{32'h0, STATUS_OK}},
      // Two points at the same x: the later one wins at and above that x.
      '{OP_ADD, 32'h0001_0000, 32'h0001_0000, 32'h0, 1, 1'b1, '{32'h0, STATUS_OK}},
      '{OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0, 1, 1'b1, '{32'h0, STATUS_OK}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h0001_0000, 1, 1'b1, '{32'h0002_0000, STATUS_OK}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h0000_8000, 1, 1'b1, '{32'h0001_0000, STATUS_OK}},
      '{OP_ADD, 32'h0003_0000, 32'hFFFF_0000, 32'h0, 1, 1'b1, '{32'h0, STATUS_OK}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h0002_0000, 1, 1'b0, '{32'h0, STATUS_OK}},
      // Fill the table, then one add too many.
      '{OP_ADD, 32'h0002_0000, 32'h7FFF_0000, 32'h0, 13, 1'b1, '{32'h0, STATUS_OK}},
      '{OP_ADD, 32'h0, 32'h0, 32'h0, 1, 1'b1, '{32'h0, STATUS_FULL}},
      '{OP_EVAL, 32'h0, 32'h0, 32'h0002_8000, 1, 1'b0, '{32'h0, STATUS_OK}},
      '{OP_CLEAR, 32'h0, 32'h0, 32'h0, 1, 1'b1, '{32'h0, STATUS_OK}}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_plan[r]) begin
      repeat (dir_plan[r].reps)
        send_word(dir_plan[r].op, dir_plan[r].px, dir_plan[r].py, dir_plan[r].smp,
                  dir_plan[r].typed, dir_plan[r].want);
    end

    // Phase 0: no idling, with one long receiver hold-off while words keep coming.
    while (n_words < NUM_DIR + WORDS_PER_PHASE) begin
      if (hold_asks == 0 && n_words > NUM_DIR + 200) hold_asks = 1;
      send_curve(0, 0);
    end

    // Phase 1: the sender idles and first waits until every result is back.
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    while (n_words < NUM_DIR + 2 * WORDS_PER_PHASE) send_curve(59, 0);

    // Phase 2: the receiver stalls.
    while (n_words < NUM_DIR + 3 * WORDS_PER_PHASE) send_curve(0, 59);

    // Phase 3: both sides idle.
    while (n_words < NUM_DIR + 4 * WORDS_PER_PHASE) send_curve(21, 21);

    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d words: %0d clears, %0d adds (%0d refused on a full table),",
             n_words, n_clear, n_add, n_refused);
    $display("and %0d evaluates, %0d of them interpolated between two points", n_eval, n_interp);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
